/* design/mrru_pkg.sv */
// Package for the mixed-radix rank and unrank unit.
// Holds the item and configuration types, request codes and the radix decode.
// Used by every module of the unit; depends on nothing.
package mrru_pkg;

	localparam int NUM_DIGITS = 8;
	localparam int DIGIT_BITS = 8;
	localparam int RANK_BITS  = 32;
	localparam int RADIX_BITS = DIGIT_BITS + 1;
	localparam int CNT_BITS   = 4;
	localparam int IDX_BITS   = 3;
	localparam int CFG_IDX_BITS = 3;

	localparam logic [1:0] REQ_RANK_NATURAL = 2'd0;
	localparam logic [1:0] REQ_RANK_ORDER   = 2'd1;
	localparam logic [1:0] REQ_UNRANK       = 2'd2;

	localparam logic [CFG_IDX_BITS-1:0] CFG_RADIX_SET    = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_DIGIT_COUNT  = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ORDER_LIST   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ORDER_LENGTH = 3'd3;

	typedef struct packed {
		logic [1:0]            req_type;
		logic [DIGIT_BITS-1:0] in_digit_0;
		logic [DIGIT_BITS-1:0] in_digit_1;
		logic [DIGIT_BITS-1:0] in_digit_2;
		logic [DIGIT_BITS-1:0] in_digit_3;
		logic [DIGIT_BITS-1:0] in_digit_4;
		logic [DIGIT_BITS-1:0] in_digit_5;
		logic [DIGIT_BITS-1:0] in_digit_6;
		logic [DIGIT_BITS-1:0] in_digit_7;
		logic [RANK_BITS-1:0]  rank_in;
	} req_t;

	typedef struct packed {
		logic [RANK_BITS-1:0]  rank_out;
		logic [DIGIT_BITS-1:0] out_digit_0;
		logic [DIGIT_BITS-1:0] out_digit_1;
		logic [DIGIT_BITS-1:0] out_digit_2;
		logic [DIGIT_BITS-1:0] out_digit_3;
		logic [DIGIT_BITS-1:0] out_digit_4;
		logic [DIGIT_BITS-1:0] out_digit_5;
		logic [DIGIT_BITS-1:0] out_digit_6;
		logic [DIGIT_BITS-1:0] out_digit_7;
		logic                  overflow;
	} rsp_t;

	typedef struct packed {
		logic [NUM_DIGITS*DIGIT_BITS-1:0] radix_set;
		logic [CNT_BITS-1:0]              digit_count;
		logic [NUM_DIGITS*IDX_BITS-1:0]   order_list;
		logic [CNT_BITS-1:0]              order_length;
	} cfg_t;

	typedef struct packed {
		logic [1:0]                             req;
		logic [NUM_DIGITS-1:0][DIGIT_BITS-1:0]  dig;
		logic [RANK_BITS-1:0]                   acc;
		logic                                   ovf;
		logic [RANK_BITS-1:0]                   rest;
		logic [NUM_DIGITS-1:0][DIGIT_BITS-1:0]  odig;
	} pipe_t;

	function automatic logic [RADIX_BITS-1:0] radix_of(
		input logic [NUM_DIGITS*DIGIT_BITS-1:0] set,
		input logic [IDX_BITS-1:0] idx
	);
		logic [DIGIT_BITS-1:0] b;
		b = set[idx*DIGIT_BITS +: DIGIT_BITS];
		radix_of = (b == '0) ? RADIX_BITS'(1 << DIGIT_BITS) : {1'b0, b};
	endfunction

endpackage

/* design/mrru_rank_cell.sv */
// One Horner cell of the rank chain: acc = acc * radix + digit for one position.
// Uses mrru_pkg types and the radix decode.
module mrru_rank_cell #(
	parameter int INDEX = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  mrru_pkg::cfg_t cfg,
	input  logic           up_valid,
	output logic           up_ready,
	input  mrru_pkg::pipe_t up_data,
	output logic           dn_valid,
	input  logic           dn_ready,
	output mrru_pkg::pipe_t dn_data
);
	localparam int PROD_BITS = mrru_pkg::RANK_BITS + mrru_pkg::RADIX_BITS;

	logic                             vld_s1;
	mrru_pkg::pipe_t                  data_s1;
	mrru_pkg::pipe_t                  nxt;
	logic                             natural;
	logic [mrru_pkg::CNT_BITS-1:0]    cnt;
	logic [mrru_pkg::IDX_BITS-1:0]    idx;
	logic [mrru_pkg::RADIX_BITS-1:0]  r;
	logic [PROD_BITS-1:0]             prod;

	always_comb begin
		natural = (up_data.req == mrru_pkg::REQ_RANK_NATURAL);
		cnt = natural ? cfg.digit_count : cfg.order_length;
		idx = natural ? mrru_pkg::IDX_BITS'(INDEX)
			: cfg.order_list[INDEX*mrru_pkg::IDX_BITS +: mrru_pkg::IDX_BITS];
		r = mrru_pkg::radix_of(cfg.radix_set, idx);
		prod = PROD_BITS'(up_data.acc) * PROD_BITS'(r) + PROD_BITS'(up_data.dig[idx]);
		nxt = up_data;
		if ((natural || up_data.req == mrru_pkg::REQ_RANK_ORDER)
				&& mrru_pkg::CNT_BITS'(INDEX) < cnt) begin
			nxt.acc = prod[mrru_pkg::RANK_BITS-1:0];
			nxt.ovf = up_data.ovf | (|prod[PROD_BITS-1:mrru_pkg::RANK_BITS]);
		end
	end

	assign up_ready = !vld_s1 || dn_ready;
	assign dn_valid = vld_s1;
	assign dn_data = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (up_ready) begin
			vld_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s1 <= nxt;
		end
	end
endmodule

/* design/mrru_bit_cell.sv */
// One bit step of unranking: shifts one rank bit into the row of mixed-radix digits.
// Uses mrru_pkg types and the radix decode.
module mrru_bit_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  mrru_pkg::cfg_t cfg,
	input  logic           up_valid,
	output logic           up_ready,
	input  mrru_pkg::pipe_t up_data,
	output logic           dn_valid,
	input  logic           dn_ready,
	output mrru_pkg::pipe_t dn_data
);
	logic                            vld_s1;
	mrru_pkg::pipe_t                 data_s1;
	mrru_pkg::pipe_t                 nxt;
	logic                            c;
	logic [mrru_pkg::RADIX_BITS-1:0] v;
	logic [mrru_pkg::RADIX_BITS-1:0] r;

	always_comb begin
		nxt = up_data;
		c = up_data.rest[mrru_pkg::RANK_BITS-1];
		v = '0;
		r = '0;
		if (up_data.req == mrru_pkg::REQ_UNRANK) begin
			nxt.rest = {up_data.rest[mrru_pkg::RANK_BITS-2:0], 1'b0};
			for (int k = mrru_pkg::NUM_DIGITS - 1; k >= 0; k--) begin
				if (mrru_pkg::CNT_BITS'(k) < cfg.digit_count) begin
					r = mrru_pkg::radix_of(cfg.radix_set, mrru_pkg::IDX_BITS'(k));
					v = {up_data.odig[k], c};
					if (v >= r) begin
						v = v - r;
						c = 1'b1;
					end else begin
						c = 1'b0;
					end
					nxt.odig[k] = v[mrru_pkg::DIGIT_BITS-1:0];
				end
			end
			nxt.ovf = up_data.ovf | c;
		end
	end

	assign up_ready = !vld_s1 || dn_ready;
	assign dn_valid = vld_s1;
	assign dn_data = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (up_ready) begin
			vld_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s1 <= nxt;
		end
	end
endmodule

/* design/mixed_radix_rank_unrank_unit.sv */
// Top level of the mixed-radix rank and unrank unit.
// Depends on mrru_pkg, mrru_rank_cell and mrru_bit_cell.
//
// Requests enter on req with req_valid and req_stall; results leave on rsp
// with rsp_valid and rsp_stall. An item moves when valid is high and stall
// is low. Configuration registers are written on the cfg channel, which is
// always ready, and must only be written while no item is in flight.
// Every request gives one result, after passing through eight
// Horner cells (one per digit position) followed by 32 unranking cells (one
// per rank bit). One item is accepted per cycle while req_stall is low.
// Each cell holds its own item, so a stalled receiver fills the chain from the
// end; the chain keeps taking items until every cell is occupied and then
// stalls the sender. Results stay in order.
// Reset empties the chain at once and restores all radices to 256 and both
// counts to eight.
module mixed_radix_rank_unrank_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  mrru_pkg::req_t                       req,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output mrru_pkg::rsp_t                       rsp,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mrru_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [63:0]                          cfg_data
);
	localparam int RANK_CELLS = mrru_pkg::NUM_DIGITS;
	localparam int BIT_CELLS  = mrru_pkg::RANK_BITS;
	localparam int CELLS      = RANK_CELLS + BIT_CELLS;

	mrru_pkg::cfg_t  cfg_q;
	mrru_pkg::pipe_t chain_data [CELLS+1];
	logic            chain_valid [CELLS+1];
	logic            chain_ready [CELLS+1];
	mrru_pkg::pipe_t last;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radix_set    <= '0;
			cfg_q.digit_count  <= mrru_pkg::CNT_BITS'(mrru_pkg::NUM_DIGITS);
			cfg_q.order_list   <= '0;
			cfg_q.order_length <= mrru_pkg::CNT_BITS'(mrru_pkg::NUM_DIGITS);
		end else if (cfg_valid) begin
			case (cfg_index)
				mrru_pkg::CFG_RADIX_SET: begin
					cfg_q.radix_set <= cfg_data;
				end
				mrru_pkg::CFG_DIGIT_COUNT: begin
					cfg_q.digit_count <= cfg_data[mrru_pkg::CNT_BITS-1:0];
				end
				mrru_pkg::CFG_ORDER_LIST: begin
					cfg_q.order_list <= cfg_data[mrru_pkg::NUM_DIGITS*mrru_pkg::IDX_BITS-1:0];
				end
				mrru_pkg::CFG_ORDER_LENGTH: begin
					cfg_q.order_length <= cfg_data[mrru_pkg::CNT_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		chain_data[0].req     = req.req_type;
		chain_data[0].dig[0]  = req.in_digit_0;
		chain_data[0].dig[1]  = req.in_digit_1;
		chain_data[0].dig[2]  = req.in_digit_2;
		chain_data[0].dig[3]  = req.in_digit_3;
		chain_data[0].dig[4]  = req.in_digit_4;
		chain_data[0].dig[5]  = req.in_digit_5;
		chain_data[0].dig[6]  = req.in_digit_6;
		chain_data[0].dig[7]  = req.in_digit_7;
		chain_data[0].acc     = '0;
		chain_data[0].ovf     = 1'b0;
		chain_data[0].rest    = req.rank_in;
		chain_data[0].odig    = '0;
	end

	assign chain_valid[0] = req_valid;
	assign req_stall = !chain_ready[0];

	for (genvar i = 0; i < RANK_CELLS; i++) begin : g_rank
		mrru_rank_cell #(.INDEX(i)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cfg      (cfg_q),
			.up_valid (chain_valid[i]),
			.up_ready (chain_ready[i]),
			.up_data  (chain_data[i]),
			.dn_valid (chain_valid[i+1]),
			.dn_ready (chain_ready[i+1]),
			.dn_data  (chain_data[i+1])
		);
	end

	for (genvar j = RANK_CELLS; j < CELLS; j++) begin : g_bit
		mrru_bit_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cfg      (cfg_q),
			.up_valid (chain_valid[j]),
			.up_ready (chain_ready[j]),
			.up_data  (chain_data[j]),
			.dn_valid (chain_valid[j+1]),
			.dn_ready (chain_ready[j+1]),
			.dn_data  (chain_data[j+1])
		);
	end

	assign chain_ready[CELLS] = !rsp_stall;
	assign rsp_valid = chain_valid[CELLS];
	assign last = chain_data[CELLS];

	always_comb begin
		rsp.rank_out    = last.acc;
		rsp.out_digit_0 = last.odig[0];
		rsp.out_digit_1 = last.odig[1];
		rsp.out_digit_2 = last.odig[2];
		rsp.out_digit_3 = last.odig[3];
		rsp.out_digit_4 = last.odig[4];
		rsp.out_digit_5 = last.odig[5];
		rsp.out_digit_6 = last.odig[6];
		rsp.out_digit_7 = last.odig[7];
		rsp.overflow    = last.ovf;
	end
endmodule

/* bench/mrru_checker.sv */
// Checker for the mixed-radix rank and unrank unit: watches the request,
// result and configuration channels, predicts each result and compares.
// Depends on mrru_pkg.
module mrru_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	input  logic                              req_stall,
	input  mrru_pkg::req_t                    req,
	input  logic                              rsp_valid,
	input  logic                              rsp_stall,
	input  mrru_pkg::rsp_t                    rsp,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [mrru_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [63:0]                       cfg_data,
	output int                                fail_count,
	output int                                pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import mrru_pkg::*;

	logic [63:0] m_radix;
	logic [3:0]  m_count;
	logic [23:0] m_order;
	logic [3:0]  m_olen;
	rsp_t        awaited_rsp[$];
	int          mismatches;

	function automatic logic [8:0] radix_at(input int i);
		logic [7:0] b;
		b = m_radix[i*8 +: 8];
		return (b == 8'd0) ? 9'd256 : {1'b0, b};
	endfunction

	function automatic rsp_t convert(input req_t q);
		rsp_t r;
		logic [7:0] d[8];
		logic [63:0] acc, base, rest, rd;
		int n, idx;
		r = '0;
		d[0] = q.in_digit_0; d[1] = q.in_digit_1; d[2] = q.in_digit_2;
		d[3] = q.in_digit_3; d[4] = q.in_digit_4; d[5] = q.in_digit_5;
		d[6] = q.in_digit_6; d[7] = q.in_digit_7;
		acc = 0;
		base = 1;
		if (q.req_type == REQ_RANK_NATURAL || q.req_type == REQ_RANK_ORDER) begin
			n = (q.req_type == REQ_RANK_NATURAL) ? m_count : m_olen;
			if (n > 8) n = 8;
			for (int k = n - 1; k >= 0; k--) begin
				idx = (q.req_type == REQ_RANK_NATURAL) ? k : m_order[3*k +: 3];
				acc += 64'(d[idx]) * base;
				if (k > 0) base *= 64'(radix_at(idx));
			end
			r.rank_out = acc[31:0];
			r.overflow = (acc[63:32] != 0);
		end else if (q.req_type == REQ_UNRANK) begin
			logic [7:0] o[8];
			for (int i = 0; i < 8; i++) o[i] = 0;
			rest = 64'(q.rank_in);
			n = (m_count > 8) ? 8 : m_count;
			for (int k = n - 1; k >= 0; k--) begin
				rd = 64'(radix_at(k));
				o[k] = 8'(rest % rd);
				rest = rest / rd;
			end
			r.out_digit_0 = o[0]; r.out_digit_1 = o[1]; r.out_digit_2 = o[2];
			r.out_digit_3 = o[3]; r.out_digit_4 = o[4]; r.out_digit_5 = o[5];
			r.out_digit_6 = o[6]; r.out_digit_7 = o[7];
			r.overflow = (rest != 0);
		end
		return r;
	endfunction

	assign fail_count = mismatches;

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			m_radix <= '0;
			m_count <= 4'd8;
			m_order <= '0;
			m_olen <= 4'd8;
			awaited_rsp.delete();
			mismatches <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_RADIX_SET: m_radix <= cfg_data;
					CFG_DIGIT_COUNT: m_count <= cfg_data[3:0];
					CFG_ORDER_LIST: m_order <= cfg_data[23:0];
					CFG_ORDER_LENGTH: m_olen <= cfg_data[3:0];
					default: ;
				endcase
			end
			if (rsp_valid && !rsp_stall) begin
				if (awaited_rsp.size() == 0) begin
					if (mismatches < 10) $display("unexpected result %h", rsp);
					mismatches <= mismatches + 1;
				end else begin
					want = awaited_rsp.pop_front();
					if (want !== rsp) begin
						if (mismatches < 10)
							$display("mismatch: expected %h actual %h", want, rsp);
						mismatches <= mismatches + 1;
					end
				end
			end
			if (req_valid && !req_stall) awaited_rsp.push_back(convert(req));
			pending <= awaited_rsp.size();
		end
	end
endmodule

/* bench/mixed_radix_rank_unrank_unit_tb.sv */
// Top of the bench for the mixed-radix rank and unrank unit: drives requests
// and configuration phases with random gaps and stalls, and gives the verdict.
// Depends on mrru_pkg, mrru_checker and the unit itself.
module mixed_radix_rank_unrank_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mrru_pkg::*;

	logic clk, arst_n;
	logic req_valid, req_stall, rsp_valid, rsp_stall, cfg_valid, cfg_ready;
	req_t req;
	rsp_t rsp;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [63:0] cfg_data;
	int fail_count, pending;
	bit hold_rx, long_hold;

	mixed_radix_rank_unrank_unit DUT (.*);

	mrru_checker u_checker (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("FAIL");
		$finish;
	end

	initial begin
		rsp_stall = 0;
		@(posedge arst_n);
		forever begin
			int w;
			w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
			if (hold_rx) w = 0;
			@(posedge clk);
			if (long_hold) begin
				rsp_stall <= 1;
				repeat (120) @(posedge clk);
				rsp_stall <= 0;
				long_hold = 0;
			end else if (w > 0) begin
				rsp_stall <= 1;
				repeat (w) @(posedge clk);
				rsp_stall <= 0;
			end else rsp_stall <= 0;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [63:0] v);
		@(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
	endtask

	task automatic drain;
		req_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (45) @(posedge clk);
	endtask

	task automatic send_item(input req_t q, input bit gaps);
		int w;
		w = gaps && $urandom_range(0, 2) != 0 ? $urandom_range(0, 18) : 0;
		if (w > 0) begin
			req_valid <= 0;
			repeat (w) @(posedge clk);
		end
		req_valid <= 1;
		req <= q;
		do @(posedge clk); while (req_stall);
	endtask

	function automatic req_t rand_item(input int mode);
		req_t q;
		q = '0;
		{q.in_digit_0, q.in_digit_1, q.in_digit_2, q.in_digit_3,
			q.in_digit_4, q.in_digit_5, q.in_digit_6, q.in_digit_7} = {$urandom, $urandom};
		q.rank_in = $urandom;
		q.req_type = mode < 0 ? 2'($urandom_range(0, 3)) : 2'(mode);
		if ($urandom_range(0, 3) == 0) q.rank_in = $urandom_range(0, 300);
		return q;
	endfunction

	// Sends items back to back with no deassert between them.
	task automatic send_burst(input int count);
		for (int i = 0; i < count; i++) begin
			req_valid <= 1;
			req <= rand_item(-1);
			do @(posedge clk); while (req_stall);
		end
	endtask

	initial begin
		req_t q;
		logic [63:0] radix_opts[4];
		arst_n = 0;
		req_valid = 0;
		req = '0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		hold_rx = 0;
		long_hold = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		q = '0;
		send_item(q, 0);
		q = '1; q.req_type = REQ_RANK_NATURAL; send_item(q, 0);
		q.req_type = REQ_RANK_ORDER; send_item(q, 0);
		q.req_type = REQ_UNRANK; send_item(q, 0);
		q.req_type = 2'd3; send_item(q, 0);
		q = '0; q.req_type = REQ_UNRANK; q.rank_in = 32'd1; send_item(q, 0);
		drain();

		radix_opts[0] = 64'h0;
		radix_opts[1] = 64'h0101010101010101;
		radix_opts[2] = 64'hFFFFFFFFFFFFFFFF;
		radix_opts[3] = 64'h0302050A00071004;
		for (int ph = 0; ph < 24; ph++) begin
			write_reg(CFG_RADIX_SET, ph < 4 ? radix_opts[ph] :
				($urandom_range(0, 1) ? {$urandom, $urandom} : radix_opts[$urandom_range(0, 3)]));
			write_reg(CFG_DIGIT_COUNT, ph == 0 ? 64'd0 : ph == 1 ? 64'd15 :
				ph == 2 ? 64'd1 : 64'($urandom_range(0, 15)));
			write_reg(CFG_ORDER_LIST, ph == 0 ? 64'hFFFFFF : 64'($urandom));
			write_reg(CFG_ORDER_LENGTH, ph == 0 ? 64'd0 : ph == 1 ? 64'd15 :
				ph == 2 ? 64'd1 : 64'($urandom_range(0, 15)));
			if (ph < 4) begin
				for (int m = 0; m < 4; m++) begin
					q = '1; q.req_type = 2'(m); send_item(q, 0);
				end
			end
			if (ph == 5) begin
				long_hold = 1;
				send_burst(60);
			end
			if (ph == 9) hold_rx = 1;
			for (int i = 0; i < 62; i++) send_item(rand_item(-1), ph != 9);
			hold_rx = 0;
			drain();
		end

		drain();
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
